[rtl/dsms_pkg.sv]
// shared types, constants and helpers for the debounced switch mute sequencer
`timescale 1ns / 1ps
`default_nettype none

package dsms_pkg;

  localparam int unsigned SETTLE_W  = 6;
  localparam int unsigned CONFIRM_W = 4;
  localparam int unsigned HOLD_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned STAGE_W   = 2;

  localparam logic [SETTLE_W-1:0]  SETTLE_MAX  = '1;
  localparam logic [CONFIRM_W-1:0] CONFIRM_MAX = '1;
  localparam logic [HOLD_W-1:0]    HOLD_MAX    = '1;

  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = 6'd21;
  localparam logic [CONFIRM_W-1:0] CONFIRM_RST = 4'd5;
  localparam logic [HOLD_W-1:0]    HOLD_RST    = 8'd43;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_READS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS      = 2'd2;

  // stage codes as seen on the result channel
  localparam logic [STAGE_W-1:0] STAGE_IDLE  = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_START = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_HOLD1 = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_HOLD2 = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_HOLD1 = 4'b0100,
    ST_HOLD2 = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic               mute_drive;
    logic               audio_switch_high;
    logic               switch_state;
    logic [STAGE_W-1:0] stage;
  } dsms_result_t;

  function automatic logic [STAGE_W-1:0] stage_code(input seq_state_t st);
    logic [STAGE_W-1:0] code;
    case (st)
      ST_IDLE:  code = STAGE_IDLE;
      ST_START: code = STAGE_START;
      ST_HOLD1: code = STAGE_HOLD1;
      ST_HOLD2: code = STAGE_HOLD2;
      default:  code = STAGE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/dsms_if.sv]
// valid/ready channel interfaces for sample items and result items
`timescale 1ns / 1ps
`default_nettype none

interface dsms_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic tick;

  modport source (output valid, output pin_level, output tick, input ready);
  modport sink   (input valid, input pin_level, input tick, output ready);
endinterface

interface dsms_out_if;
  logic       valid;
  logic       ready;
  logic       mute_drive;
  logic       audio_switch_high;
  logic       switch_state;
  logic [1:0] stage;

  modport source (output valid, output mute_drive, output audio_switch_high,
                  output switch_state, output stage, input ready);
  modport sink   (input valid, input mute_drive, input audio_switch_high,
                  input switch_state, input stage, output ready);
endinterface

`default_nettype wire

[rtl/dsms_core.sv]
// debounce, sampling and mute sequencer state with per-transfer next-state logic
`timescale 1ns / 1ps
`default_nettype none

module dsms_core import dsms_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 push,
  input  wire logic                 pin_level,
  input  wire logic                 tick,
  output dsms_result_t              res_nxt
);

  logic [SETTLE_W-1:0]  settle_reads_r;
  logic [CONFIRM_W-1:0] confirm_samples_r;
  logic [HOLD_W-1:0]    hold_ticks_r;

  logic                 last_raw_r, last_raw_nxt;
  logic [SETTLE_W-1:0]  settle_run_r, settle_run_nxt;
  logic                 pending_r, pending_nxt;
  logic                 sampled_r, sampled_nxt;
  logic [CONFIRM_W-1:0] match_r, match_nxt;
  logic                 deb_r, deb_nxt;
  seq_state_t           state_r, state_nxt;
  logic [HOLD_W-1:0]    hold_r, hold_nxt;
  logic                 mute_r, mute_nxt;
  logic                 audio_r, audio_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_reads_r    <= SETTLE_RST;
      confirm_samples_r <= CONFIRM_RST;
      hold_ticks_r      <= HOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SETTLE_READS:    settle_reads_r    <= cfg_data[SETTLE_W-1:0];
        CFG_CONFIRM_SAMPLES: confirm_samples_r <= cfg_data[CONFIRM_W-1:0];
        CFG_HOLD_TICKS:      hold_ticks_r      <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    last_raw_nxt   = last_raw_r;
    settle_run_nxt = settle_run_r;
    pending_nxt    = pending_r;
    sampled_nxt    = sampled_r;
    match_nxt      = match_r;
    deb_nxt        = deb_r;
    state_nxt      = state_r;
    hold_nxt       = hold_r;
    mute_nxt       = mute_r;
    audio_nxt      = audio_r;

    // run of equal raw reads
    if (pin_level != last_raw_r) begin
      last_raw_nxt   = pin_level;
      settle_run_nxt = '0;
    end else if (settle_run_r != SETTLE_MAX) begin
      settle_run_nxt = settle_run_r + 1'b1;
    end

    if (tick) begin
      pending_nxt = 1'b1;
      if (hold_r != HOLD_MAX) hold_nxt = hold_r + 1'b1;
    end

    if (pending_nxt && (state_r == ST_IDLE) && (settle_run_nxt >= settle_reads_r)) begin
      if (sampled_r == last_raw_nxt) begin
        if (match_r != CONFIRM_MAX) match_nxt = match_r + 1'b1;
      end else begin
        match_nxt   = '0;
        sampled_nxt = last_raw_nxt;
      end
      if (match_nxt >= confirm_samples_r) begin
        match_nxt = '0;
        if (deb_r != sampled_nxt) begin
          deb_nxt   = sampled_nxt;
          state_nxt = ST_START;
        end
      end
      pending_nxt = 1'b0;
    end

    // stages may chain within one transfer when their hold is already met
    if (state_nxt == ST_START) begin
      mute_nxt  = 1'b1;
      hold_nxt  = '0;
      state_nxt = ST_HOLD1;
    end
    if ((state_nxt == ST_HOLD1) && (hold_nxt >= hold_ticks_r)) begin
      state_nxt = ST_HOLD2;
      audio_nxt = ~deb_nxt;
      hold_nxt  = '0;
    end
    if ((state_nxt == ST_HOLD2) && (hold_nxt >= hold_ticks_r)) begin
      mute_nxt  = 1'b0;
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r   <= 1'b0;
      settle_run_r <= '0;
      pending_r    <= 1'b0;
      sampled_r    <= 1'b0;
      match_r      <= '0;
      deb_r        <= 1'b0;
      state_r      <= ST_IDLE;
      hold_r       <= '0;
      mute_r       <= 1'b0;
      audio_r      <= 1'b1;
    end else if (push) begin
      last_raw_r   <= last_raw_nxt;
      settle_run_r <= settle_run_nxt;
      pending_r    <= pending_nxt;
      sampled_r    <= sampled_nxt;
      match_r      <= match_nxt;
      deb_r        <= deb_nxt;
      state_r      <= state_nxt;
      hold_r       <= hold_nxt;
      mute_r       <= mute_nxt;
      audio_r      <= audio_nxt;
    end
  end

  always_comb begin
    res_nxt.mute_drive        = mute_nxt;
    res_nxt.audio_switch_high = audio_nxt;
    res_nxt.switch_state      = deb_nxt;
    res_nxt.stage             = stage_code(state_nxt);
  end

endmodule

`default_nettype wire

[rtl/dsms_out_buf.sv]
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps
`default_nettype none

module dsms_out_buf import dsms_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dsms_result_t  res_in,
  output logic               can_push,
  dsms_out_if.source         out_if
);

  logic         out_valid_r;
  logic         skid_valid_r;
  dsms_result_t out_data_r;
  dsms_result_t skid_data_r;
  logic         pop;

  assign pop      = out_valid_r && out_if.ready;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else if (!push) begin
        out_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= res_in;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_data_r <= res_in;
      end else begin
        out_data_r <= res_in;
      end
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.mute_drive        = out_data_r.mute_drive;
  assign out_if.audio_switch_high = out_data_r.audio_switch_high;
  assign out_if.switch_state      = out_data_r.switch_state;
  assign out_if.stage             = out_data_r.stage;

endmodule

`default_nettype wire

[rtl/debounced_switch_mute_sequencer_unit.sv]
// top level of the debounced switch mute sequencer
//
//   channel  dir  transfer fields
//   in_if    in   pin_level, tick
//   out_if   out  mute_drive, audio_switch_high, switch_state, stage
//   cfg_*    in   cfg_index selects settle_reads / confirm_samples / hold_ticks
//
// one sample transfer per cycle while in_if.ready is high; its result is registered
// all state updates in one pass of next-state logic between the state and result registers
// a two-entry output buffer keeps in_if.ready high while one result waits
// in_if.ready drops only when both buffer entries hold results
// synchronous active-low reset restores register defaults and idle stage
`timescale 1ns / 1ps
`default_nettype none

module debounced_switch_mute_sequencer_unit import dsms_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  dsms_in_if.sink                   in_if,
  dsms_out_if.source                out_if,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic         push;
  logic         can_push;
  dsms_result_t res_nxt;

  assign in_if.ready = can_push;
  assign push        = in_if.valid && can_push;

  dsms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .pin_level (in_if.pin_level),
    .tick      (in_if.tick),
    .res_nxt   (res_nxt)
  );

  dsms_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res_in   (res_nxt),
    .can_push (can_push),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire

[rtl/dsms_checker.sv]
// port-level checker for the debounced switch mute sequencer and its bind
`timescale 1ns / 1ps
`default_nettype none

module dsms_checker import dsms_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               mute_drive,
  input wire logic               audio_switch_high,
  input wire logic               switch_state,
  input wire logic [STAGE_W-1:0] stage
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(stage) && $stable(mute_drive)
      && $stable(audio_switch_high) && $stable(switch_state))
    else $error("stalled result changed");

  // input back-pressure only with a result waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // mute is driven exactly while a hold stage runs, start never shows
  a_mute: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mute_drive == (stage != STAGE_IDLE)) && (stage != STAGE_START))
    else $error("mute and stage disagree");

  // once idle, the audio switch is the inverse of the switch state
  a_audio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (stage == STAGE_IDLE) |-> (audio_switch_high == !switch_state))
    else $error("audio switch out of step with switch state");

endmodule

bind debounced_switch_mute_sequencer_unit dsms_checker u_dsms_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .mute_drive        (out_if.mute_drive),
  .audio_switch_high (out_if.audio_switch_high),
  .switch_state      (out_if.switch_state),
  .stage             (out_if.stage)
);

`default_nettype wire
